@@ hdl/b64_pkg.sv @@
// Shared types, codes and character functions of the Base64 stream codec.
// Used by every module under hdl; depends on nothing else.
package b64_pkg;

  // Decoded value codes beyond the 64 alphabet values.
  localparam logic [6:0] VAL_PAD = 7'd64;
  localparam logic [6:0] VAL_BAD = 7'd65;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'

  localparam logic       MODE_ENCODE = 1'b0;
  localparam logic       MODE_DECODE = 1'b1;

  // One queued job: up to four result bytes, index of the last one, error flag.
  typedef struct packed {
    logic [31:0] chars;     // result k in chars[8k +: 8]
    logic [1:0]  last_idx;  // index of the final result of this job
    logic        err;       // job is the single error result
  } job_t;

  // Six-bit value to alphabet character.
  function automatic logic [7:0] to_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26)       r = 8'h41 + {2'b00, v};
    else if (v < 6'd52)  r = 8'h61 + {2'b00, v - 6'd26};
    else if (v < 6'd62)  r = 8'h30 + {2'b00, v - 6'd52};
    else if (v == 6'd62) r = CHAR_PLUS;
    else                 r = CHAR_SLASH;
    return r;
  endfunction

  // Character to value: 0..63 for the alphabet, VAL_PAD, or VAL_BAD.
  function automatic logic [6:0] from_char(input logic [7:0] c);
    logic [6:0] r;
    if (c >= 8'h41 && c <= 8'h5A)      r = 7'(c - 8'h41);
    else if (c >= 8'h61 && c <= 8'h7A) r = 7'(c - 8'h61 + 8'd26);
    else if (c >= 8'h30 && c <= 8'h39) r = 7'(c - 8'h30 + 8'd52);
    else if (c == CHAR_PLUS)           r = 7'd62;
    else if (c == CHAR_SLASH)          r = 7'd63;
    else if (c == CHAR_PAD)            r = VAL_PAD;
    else                               r = VAL_BAD;
    return r;
  endfunction

endpackage

@@ hdl/base64_stream_codec.sv @@
// Base64 stream codec: one item enters per cycle while the job queue has room;
// results leave at one per cycle while the output is ready, so encode gives four
// results per group of three items and the output port sets the rate. Each job is registered in the job queue first.
// Synchronous active-high reset sets encode mode, clears the stream state and
// empties the job queue. Uses b64_pkg, b64_front, b64_queue and b64_back.
module base64_stream_codec import b64_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,  // decode_mode
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,      // in_byte
  input  logic       s_tlast,      // end_of_stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,      // out_byte
  output logic       m_tlast,      // out_last
  output logic       m_tuser       // error
);

  logic accept;
  logic job_valid;
  job_t job;
  logic push;
  logic pop;
  logic full;
  logic head_valid;
  job_t head_job;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && job_valid;

  b64_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .accept        (accept),
    .in_byte       (s_tdata),
    .end_of_stream (s_tlast),
    .job_valid     (job_valid),
    .job           (job)
  );

  b64_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (job),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  b64_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

  // An error result is always the only, and so the last, result of its item.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'h00))
    else $error("error result not marked last");

  // No job is pushed into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("job queue overflow");

  // Nothing is offered on the output right after a reset cycle.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A stalled result does not block a push when the queue has room.
  a_decoupled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready && !full |-> s_tready)
    else $error("input stalled behind output");

endmodule

@@ hdl/b64_front.sv @@
// Front end of the Base64 codec: holds the mode and group state, classifies
// each accepted item and builds the job of results it causes. Uses b64_pkg.
module b64_front import b64_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       end_of_stream,
  output logic       job_valid,
  output job_t       job
);

  logic        decode_mode;
  logic [23:0] group_buffer;
  logic [1:0]  fill_count;
  logic [1:0]  pad_count;
  logic        error_seen;

  logic [23:0] group_buffer_next;
  logic [1:0]  fill_count_next;
  logic [1:0]  pad_count_next;
  logic        error_seen_next;

  logic [2:0]  fill_inc;
  logic [6:0]  val;
  logic        bad;
  logic        emit;
  logic [23:0] shifted;

  // Next group state and the job for the current item.
  always_comb begin
    group_buffer_next = group_buffer;
    fill_count_next   = fill_count;
    pad_count_next    = pad_count;
    error_seen_next   = error_seen;
    fill_inc          = {1'b0, fill_count} + 3'd1;
    val               = from_char(in_byte);
    bad               = 1'b0;
    emit              = 1'b0;
    shifted           = '0;
    job_valid         = 1'b0;
    job               = '0;

    if (decode_mode == MODE_ENCODE) begin
      unique case (fill_count)
        2'd0:    shifted = {in_byte, 16'h0000};
        2'd1:    shifted = {8'h00, in_byte, 8'h00};
        default: shifted = {16'h0000, in_byte};
      endcase
      group_buffer_next = group_buffer | shifted;
      emit = (fill_inc == 3'd3) || end_of_stream;
      if (emit) begin
        for (int k = 0; k < 4; k++) begin
          if (3'(k) <= fill_inc) begin
            job.chars[8*k +: 8] = to_char(group_buffer_next[23 - 6*k -: 6]);
          end else begin
            job.chars[8*k +: 8] = CHAR_PAD;
          end
        end
        job.last_idx      = 2'd3;
        job_valid         = 1'b1;
        group_buffer_next = '0;
        fill_count_next   = 2'd0;
      end else begin
        fill_count_next = fill_inc[1:0];
      end
    end else if (!error_seen) begin
      // Classify the character against the position in the group.
      if (fill_count == 2'd0 && pad_count != 2'd0) begin
        bad = 1'b1;
      end else if (val == VAL_PAD) begin
        if (fill_count < 2'd2) begin
          bad = 1'b1;
        end else begin
          pad_count_next = pad_count + 2'd1;
        end
      end else if (val == VAL_BAD || pad_count != 2'd0) begin
        bad = 1'b1;
      end else begin
        unique case (fill_count)
          2'd0:    shifted = {val[5:0], 18'h0};
          2'd1:    shifted = {6'h0, val[5:0], 12'h0};
          2'd2:    shifted = {12'h0, val[5:0], 6'h0};
          default: shifted = {18'h0, val[5:0]};
        endcase
        group_buffer_next = group_buffer | shifted;
      end

      // A complete group gives three bytes less one per pad character.
      emit = !bad && (fill_count == 2'd3);
      if (emit) begin
        job.chars         = {8'h00, group_buffer_next};
        job.chars[23:0]   = {group_buffer_next[7:0], group_buffer_next[15:8],
                             group_buffer_next[23:16]};
        job.last_idx      = 2'd2 - pad_count_next;
        job_valid         = 1'b1;
        group_buffer_next = '0;
        fill_count_next   = 2'd0;
      end else if (!bad) begin
        fill_count_next = fill_inc[1:0];
      end

      // A stream that ends inside a group is truncated and flagged as an error.
      if (!bad && end_of_stream && !emit) bad = 1'b1;

      if (bad) begin
        job             = '0;
        job.err         = 1'b1;
        job_valid       = 1'b1;
        error_seen_next = 1'b1;
      end
    end
  end

  // Mode register and stream state; reset, end of stream or a mode write clears it.
  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode  <= MODE_ENCODE;
      group_buffer <= '0;
      fill_count   <= '0;
      pad_count    <= '0;
      error_seen   <= 1'b0;
    end else if (cfg_wr_en) begin
      decode_mode  <= cfg_wr_data;
      group_buffer <= '0;
      fill_count   <= '0;
      pad_count    <= '0;
      error_seen   <= 1'b0;
    end else if (accept) begin
      if (end_of_stream) begin
        group_buffer <= '0;
        fill_count   <= '0;
        pad_count    <= '0;
        error_seen   <= 1'b0;
      end else begin
        group_buffer <= group_buffer_next;
        fill_count   <= fill_count_next;
        pad_count    <= pad_count_next;
        error_seen   <= error_seen_next;
      end
    end
  end

endmodule

@@ hdl/b64_queue.sv @@
// Job queue between the front and back ends of the Base64 codec, built of
// registers with read and write pointers. Uses job_t from b64_pkg.
module b64_queue import b64_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head_job
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  job_t            slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full       = (count == CntW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

endmodule

@@ hdl/b64_back.sv @@
// Back end of the Base64 codec: plays out the results of the head job one
// per cycle, while the output is ready, on the output stream. Uses job_t from b64_pkg.
module b64_back import b64_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  job_t       head_job,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic       m_tlast,   // out_last
  output logic       m_tuser    // error
);

  logic [1:0] res_idx;
  logic       take;

  // Current result of the head job.
  assign m_tvalid = head_valid;
  assign m_tdata  = head_job.chars[8*res_idx +: 8];
  assign m_tlast  = (res_idx == head_job.last_idx);
  assign m_tuser  = head_job.err;
  assign take     = m_tvalid && m_tready;
  assign pop      = take && m_tlast;

  // Step through the results; the last one releases the job.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_idx <= '0;
    end else if (take) begin
      res_idx <= m_tlast ? 2'd0 : res_idx + 2'd1;
    end
  end

endmodule
